// File: src/ctc_pkg.sv
// Shared types and constants for the cell traversability cost pipeline.
package ctc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_HEADROOM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_LIMIT_SQ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOPE_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_GAIN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BARRIER_COST   = 3'd5;

    localparam logic [15:0] RST_MIN_HEADROOM   = 16'd1000;
    localparam logic [39:0] RST_SLOPE_LIMIT_SQ = 40'd10000;
    localparam logic [31:0] RST_SLOPE_GAIN     = 32'd0;
    localparam logic [15:0] RST_MAX_STEP       = 16'd0;
    localparam logic [31:0] RST_STEP_GAIN      = 32'd0;
    localparam logic [15:0] RST_BARRIER_COST   = 16'd12800;

    localparam logic [15:0] COST_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] min_headroom;
        logic [39:0] slope_limit_sq;
        logic [31:0] slope_gain;
        logic [15:0] max_step;
        logic [31:0] step_gain;
        logic [15:0] barrier_cost;
    } ctc_cfg_t;

    // squared differences per neighbor plus step data
    typedef struct packed {
        logic [3:0][63:0] sq;
        logic [16:0]      delta;     // largest step, clipped at 2^16
        logic             step_en;   // centre ground valid and some neighbor valid
        logic             border;
        logic             head_bar;
    } ctc_sq_t;

    typedef struct packed {
        logic [39:0] s;
        logic        slope_ok;
        logic        step_ok;
        logic        head_bar;
        logic [15:0] delta;
    } ctc_sum_t;

endpackage

// File: src/ctc_if.sv
// Valid/ready channel interfaces for cell beats and cost beats.
interface ctc_in_if #(parameter int HEIGHT_BITS = 20);
    logic                          valid;
    logic                          ready;
    logic signed [HEIGHT_BITS-1:0] ground_height;
    logic                          ground_valid;
    logic signed [HEIGHT_BITS-1:0] ceiling_height;
    logic                          ceiling_valid;
    logic signed [HEIGHT_BITS-1:0] west_height;
    logic signed [HEIGHT_BITS-1:0] east_height;
    logic signed [HEIGHT_BITS-1:0] south_height;
    logic signed [HEIGHT_BITS-1:0] north_height;
    logic [3:0]                    neighbour_mask;
    logic                          on_border;

    modport source (
        output valid, ground_height, ground_valid, ceiling_height, ceiling_valid,
               west_height, east_height, south_height, north_height,
               neighbour_mask, on_border,
        input  ready
    );
    modport sink (
        input  valid, ground_height, ground_valid, ceiling_height, ceiling_valid,
               west_height, east_height, south_height, north_height,
               neighbour_mask, on_border,
        output ready
    );
endinterface

interface ctc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cost;
    logic        is_barrier;

    modport source (output valid, cost, is_barrier, input ready);
    modport sink (input valid, cost, is_barrier, output ready);
endinterface

// File: src/ctc_diff.sv
// Stages 1-2: headroom test, neighbor differences, squares and largest step.
module ctc_diff #(
    parameter int HEIGHT_BITS = 20
) (
    input  logic             clk,
    input  logic             rst_n,
    ctc_in_if.sink           cell_in,
    input  logic [15:0]      min_headroom,
    output logic             sq_valid,
    input  logic             sq_ready,
    output ctc_pkg::ctc_sq_t sq_data
);
    import ctc_pkg::*;

    localparam int HB  = HEIGHT_BITS;
    localparam int HW  = ((HB + 1) > 17) ? (HB + 2) : 18;
    localparam int DXW = (HB > 17) ? HB : 17;

    logic signed [HB-1:0] nb [4];
    logic signed [HB:0]   diff [4];
    logic [HB-1:0]        abs_next [4];
    logic signed [HW-1:0] ground_x;
    logic signed [HW-1:0] ceil_x;
    logic signed [HW-1:0] room;
    logic signed [HW-1:0] min_x;
    logic                 bar_next;

    logic                 s1_en;
    logic                 s2_en;
    logic                 s1_valid_reg;
    logic [HB-1:0]        s1_abs_reg [4];
    logic [3:0]           s1_mask_reg;
    logic                 s1_gv_reg;
    logic                 s1_border_reg;
    logic                 s1_bar_reg;

    logic [2*HB-1:0]      prod [4];
    logic [HB-1:0]        dmax;
    logic [DXW-1:0]       dwide;
    ctc_sq_t              sq_next;
    logic                 sq_valid_reg;
    ctc_sq_t              sq_data_reg;

    assign s2_en         = !sq_valid_reg || sq_ready;
    assign s1_en         = !s1_valid_reg || s2_en;
    assign cell_in.ready = s1_en;

    // stage 1: differences to the centre and headroom
    always_comb
    begin
        nb[0] = cell_in.west_height;
        nb[1] = cell_in.east_height;
        nb[2] = cell_in.south_height;
        nb[3] = cell_in.north_height;
        for (int k = 0; k < 4; k++)
        begin
            diff[k] = {nb[k][HB-1], nb[k]}
                    - {cell_in.ground_height[HB-1], cell_in.ground_height};
            abs_next[k] = diff[k][HB] ? HB'(-diff[k]) : diff[k][HB-1:0];
        end
        ground_x = {{(HW-HB){cell_in.ground_height[HB-1]}}, cell_in.ground_height};
        ceil_x   = {{(HW-HB){cell_in.ceiling_height[HB-1]}}, cell_in.ceiling_height};
        room     = ceil_x - ground_x;
        min_x    = HW'(min_headroom);
        bar_next = cell_in.ground_valid && cell_in.ceiling_valid && (room < min_x);
    end

    // stage 2: squares with validity rules, largest step over valid neighbors
    always_comb
    begin
        dmax = '0;
        for (int k = 0; k < 4; k++)
        begin
            prod[k] = s1_abs_reg[k] * s1_abs_reg[k];
            if (!s1_gv_reg && !s1_mask_reg[k])
                sq_next.sq[k] = '0;
            else if (s1_gv_reg != s1_mask_reg[k])
                sq_next.sq[k] = '1;
            else
                sq_next.sq[k] = 64'(prod[k]);
            if (s1_mask_reg[k] && (s1_abs_reg[k] > dmax))
                dmax = s1_abs_reg[k];
        end
        dwide           = DXW'(dmax);
        sq_next.delta   = (dwide > DXW'(17'h10000)) ? 17'h10000 : dwide[16:0];
        sq_next.step_en = s1_gv_reg && (|s1_mask_reg);
        sq_next.border  = s1_border_reg;
        sq_next.head_bar = s1_bar_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= cell_in.valid;
            if (s2_en)
                sq_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_abs_reg    <= abs_next;
            s1_mask_reg   <= cell_in.neighbour_mask;
            s1_gv_reg     <= cell_in.ground_valid;
            s1_border_reg <= cell_in.on_border;
            s1_bar_reg    <= bar_next;
        end
        if (s2_en)
            sq_data_reg <= sq_next;
    end

    assign sq_valid = sq_valid_reg;
    assign sq_data  = sq_data_reg;

endmodule

// File: src/ctc_slope.sv
// Stages 3-4: per-axis maxima, saturating sum and slope / step limit tests.
module ctc_slope (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sq_valid,
    output logic              sq_ready,
    input  ctc_pkg::ctc_sq_t  sq_data,
    input  logic [39:0]       slope_limit_sq,
    input  logic [15:0]       max_step,
    output logic              sum_valid,
    input  logic              sum_ready,
    output ctc_pkg::ctc_sum_t sum_data
);
    import ctc_pkg::*;

    logic        s3_en;
    logic        s4_en;
    logic [63:0] dx_next;
    logic [63:0] dy_next;
    logic        step_ok_next;

    logic        s3_valid_reg;
    logic [63:0] s3_dx_reg;
    logic [63:0] s3_dy_reg;
    logic        s3_step_ok_reg;
    logic        s3_bar_reg;
    logic [15:0] s3_delta_reg;

    logic [64:0] sum_wide;
    logic [63:0] s_sat;
    ctc_sum_t    sum_next;
    logic        sum_valid_reg;
    ctc_sum_t    sum_data_reg;

    assign s4_en    = !sum_valid_reg || sum_ready;
    assign s3_en    = !s3_valid_reg || s4_en;
    assign sq_ready = s3_en;

    always_comb
    begin
        if (sq_data.border)
        begin
            dx_next = '0;
            dy_next = '0;
        end
        else
        begin
            dx_next = (sq_data.sq[0] > sq_data.sq[1]) ? sq_data.sq[0] : sq_data.sq[1];
            dy_next = (sq_data.sq[2] > sq_data.sq[3]) ? sq_data.sq[2] : sq_data.sq[3];
        end
        step_ok_next = sq_data.step_en && (max_step != 16'd0)
                    && (sq_data.delta != 17'd0)
                    && (sq_data.delta <= {1'b0, max_step});
    end

    always_comb
    begin
        sum_wide          = {1'b0, s3_dx_reg} + {1'b0, s3_dy_reg};
        s_sat             = sum_wide[64] ? '1 : sum_wide[63:0];
        sum_next.s        = s_sat[39:0];
        sum_next.slope_ok = s_sat <= 64'(slope_limit_sq);
        sum_next.step_ok  = s3_step_ok_reg;
        sum_next.head_bar = s3_bar_reg;
        sum_next.delta    = s3_delta_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_en)
                s3_valid_reg <= sq_valid;
            if (s4_en)
                sum_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_en)
        begin
            s3_dx_reg      <= dx_next;
            s3_dy_reg      <= dy_next;
            s3_step_ok_reg <= step_ok_next;
            s3_bar_reg     <= sq_data.head_bar;
            s3_delta_reg   <= sq_data.delta[15:0];
        end
        if (s4_en)
            sum_data_reg <= sum_next;
    end

    assign sum_valid = sum_valid_reg;
    assign sum_data  = sum_data_reg;

endmodule

// File: src/ctc_cost.sv
// Stages 5-6: gain products, saturation to Q8.8 and the output register.
module ctc_cost (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sum_valid,
    output logic              sum_ready,
    input  ctc_pkg::ctc_sum_t sum_data,
    input  logic [31:0]       slope_gain,
    input  logic [31:0]       step_gain,
    input  logic [15:0]       barrier_cost,
    ctc_out_if.source         cost_out
);
    import ctc_pkg::*;

    logic        s5_en;
    logic        s6_en;

    logic        s5_valid_reg;
    logic [63:0] s5_plo_reg;
    logic [39:0] s5_phi_reg;
    logic [47:0] s5_pstep_reg;
    logic        s5_slope_ok_reg;
    logic        s5_step_ok_reg;
    logic        s5_bar_reg;

    logic [40:0] slope_wide;
    logic [15:0] slope_cost;
    logic [15:0] step_cost;
    logic [15:0] cost_next;
    logic        bar_next;

    logic        out_valid_reg;
    logic [15:0] out_cost_reg;
    logic        out_bar_reg;

    assign s6_en     = !out_valid_reg || cost_out.ready;
    assign s5_en     = !s5_valid_reg || s6_en;
    assign sum_ready = s5_en;

    // (s * gain) >> 32 with s below 2^40, split into a low and a high product
    always_comb
    begin
        slope_wide = {1'b0, s5_phi_reg} + 41'(s5_plo_reg[63:32]);
        slope_cost = (|slope_wide[40:16]) ? COST_MAX : slope_wide[15:0];
        step_cost  = (|s5_pstep_reg[47:32]) ? COST_MAX : s5_pstep_reg[31:16];
        if (s5_bar_reg)
        begin
            cost_next = barrier_cost;
            bar_next  = 1'b1;
        end
        else if (s5_slope_ok_reg)
        begin
            cost_next = slope_cost;
            bar_next  = 1'b0;
        end
        else if (s5_step_ok_reg)
        begin
            cost_next = step_cost;
            bar_next  = 1'b0;
        end
        else
        begin
            cost_next = barrier_cost;
            bar_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s5_en)
                s5_valid_reg <= sum_valid;
            if (s6_en)
                out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s5_en)
        begin
            s5_plo_reg      <= sum_data.s[31:0] * slope_gain;
            s5_phi_reg      <= sum_data.s[39:32] * slope_gain;
            s5_pstep_reg    <= sum_data.delta * step_gain;
            s5_slope_ok_reg <= sum_data.slope_ok;
            s5_step_ok_reg  <= sum_data.step_ok;
            s5_bar_reg      <= sum_data.head_bar;
        end
        if (s6_en)
        begin
            out_cost_reg <= cost_next;
            out_bar_reg  <= bar_next;
        end
    end

    assign cost_out.valid      = out_valid_reg;
    assign cost_out.cost       = out_cost_reg;
    assign cost_out.is_barrier = out_bar_reg;

endmodule

// File: src/cell_traversability_cost.sv
// Top level: configuration registers and the six-stage cost pipeline.
// Each accepted cell passes through six register stages, the last one being
// the output register.
// Throughput: one cell per cycle; every stage carries its own valid bit and
// stalls only when the stage after it is full and not draining.
// Reset: all pipeline valid bits clear; configuration registers take their defaults.
module cell_traversability_cost #(
    parameter int HEIGHT_BITS = 20
) (
    input  logic                             clk,
    input  logic                             rst_n,
    ctc_in_if.sink                           cell_in,
    ctc_out_if.source                        cost_out,
    input  logic                             cfg_we,
    input  logic [ctc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ctc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import ctc_pkg::*;

    ctc_cfg_t cfg_reg;
    ctc_cfg_t cfg_next;

    logic     sq_valid;
    logic     sq_ready;
    ctc_sq_t  sq_data;
    logic     sum_valid;
    logic     sum_ready;
    ctc_sum_t sum_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_HEADROOM:   cfg_next.min_headroom   = cfg_data[15:0];
                CFG_SLOPE_LIMIT_SQ: cfg_next.slope_limit_sq = cfg_data[39:0];
                CFG_SLOPE_GAIN:     cfg_next.slope_gain     = cfg_data[31:0];
                CFG_MAX_STEP:       cfg_next.max_step       = cfg_data[15:0];
                CFG_STEP_GAIN:      cfg_next.step_gain      = cfg_data[31:0];
                CFG_BARRIER_COST:   cfg_next.barrier_cost   = cfg_data[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_headroom   <= RST_MIN_HEADROOM;
            cfg_reg.slope_limit_sq <= RST_SLOPE_LIMIT_SQ;
            cfg_reg.slope_gain     <= RST_SLOPE_GAIN;
            cfg_reg.max_step       <= RST_MAX_STEP;
            cfg_reg.step_gain      <= RST_STEP_GAIN;
            cfg_reg.barrier_cost   <= RST_BARRIER_COST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ctc_diff #(
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_diff (
        .clk          (clk),
        .rst_n        (rst_n),
        .cell_in      (cell_in),
        .min_headroom (cfg_reg.min_headroom),
        .sq_valid     (sq_valid),
        .sq_ready     (sq_ready),
        .sq_data      (sq_data)
    );

    ctc_slope u_slope (
        .clk            (clk),
        .rst_n          (rst_n),
        .sq_valid       (sq_valid),
        .sq_ready       (sq_ready),
        .sq_data        (sq_data),
        .slope_limit_sq (cfg_reg.slope_limit_sq),
        .max_step       (cfg_reg.max_step),
        .sum_valid      (sum_valid),
        .sum_ready      (sum_ready),
        .sum_data       (sum_data)
    );

    ctc_cost u_cost (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_data     (sum_data),
        .slope_gain   (cfg_reg.slope_gain),
        .step_gain    (cfg_reg.step_gain),
        .barrier_cost (cfg_reg.barrier_cost),
        .cost_out     (cost_out)
    );

endmodule

// File: tb/tb_cell_traversability_cost.sv
`timescale 1ns / 1ps
// Self-checking bench for cell_traversability_cost: directed cells, then random cells per config.
module tb_cell_traversability_cost;
    import ctc_pkg::*;

    localparam int HB              = 20;
    localparam int ITEMS_PER_PHASE = 275;
    localparam int STALL_LIMIT     = 4000;
    localparam int LONG_HOLD       = 400;
    localparam int PRESET_RESET    = 0;
    localparam int PRESET_STEP     = 1;
    localparam int PRESET_MAX      = 2;
    localparam int PRESET_ZERO     = 3;
    localparam int PRESET_MID      = 4;

    typedef logic signed [HB-1:0] height_t;

    typedef struct packed {
        height_t    ground;
        logic       gv;
        height_t    ceiling;
        logic       cv;
        height_t    west;
        height_t    east;
        height_t    south;
        height_t    north;
        logic [3:0] mask;
        logic       border;
    } cell_t;

    localparam int CELL_W = $bits(cell_t);

    typedef struct packed {
        logic [15:0] cost;
        logic        barrier;
    } cost_t;

    typedef struct {
        int    sel;
        cell_t stim;
        bit    fixed;
        cost_t want;
    } cell_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ctc_in_if #(.HEIGHT_BITS(HB)) cell_if ();
    ctc_out_if                    cost_if ();

    cell_traversability_cost #(.HEIGHT_BITS(HB)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cell_in   (cell_if),
        .cost_out  (cost_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ctc_cfg_t  model_cfg;
    ctc_cfg_t  presets [5];
    cost_t     pending_costs [$];
    cell_row_t rows [$];
    cost_t     oldest;
    int        mismatches  = 0;
    int        idle_cycles = 0;
    bit        quiet       = 1'b0;
    bit        hold_now    = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // squared height difference; one side valid and the other not saturates
    function automatic logic [63:0] sq_gap(longint a, bit av, longint b, bit bv);
        longint      d;
        logic [63:0] u;
        if (!av && !bv)
            return 64'd0;
        if (av != bv)
            return '1;
        d = a - b;
        u = (d < 0) ? -d : d;
        if (u >= 64'h1_0000_0000)
            return '1;
        return u * u;
    endfunction

    function automatic cost_t predict_cost(cell_t c);
        cost_t       res;
        longint      g, ceil_mm, floor_mm, d;
        longint      nh [4];
        logic [63:0] dx, dy, slope_sum, gain, acc, u, delta;
        logic [64:0] wide;
        bit          any;
        g        = longint'(c.ground);
        ceil_mm  = longint'(c.ceiling);
        floor_mm = longint'(model_cfg.min_headroom);
        nh[0]    = longint'(c.west);
        nh[1]    = longint'(c.east);
        nh[2]    = longint'(c.south);
        nh[3]    = longint'(c.north);
        res.cost    = model_cfg.barrier_cost;
        res.barrier = 1'b1;

        if (c.gv && c.cv && (ceil_mm - g) < floor_mm)
            return res;

        slope_sum = 64'd0;
        if (!c.border)
        begin
            dx = sq_gap(g, c.gv, nh[0], c.mask[0]);
            u  = sq_gap(nh[1], c.mask[1], g, c.gv);
            dx = (u > dx) ? u : dx;
            dy = sq_gap(g, c.gv, nh[2], c.mask[2]);
            u  = sq_gap(nh[3], c.mask[3], g, c.gv);
            dy = (u > dy) ? u : dy;
            wide = {1'b0, dx} + {1'b0, dy};
            slope_sum = wide[64] ? '1 : wide[63:0];
        end

        if (slope_sum <= {24'd0, model_cfg.slope_limit_sq})
        begin
            // sum fits in 40 bits here; split it so the product stays in 64
            gain = {32'd0, model_cfg.slope_gain};
            acc  = (slope_sum >> 32) * gain + (({32'd0, slope_sum[31:0]} * gain) >> 32);
            res.cost    = (acc > 64'hFFFF) ? COST_MAX : acc[15:0];
            res.barrier = 1'b0;
            return res;
        end

        if (c.gv && model_cfg.max_step != 16'd0)
        begin
            any   = 1'b0;
            delta = 64'd0;
            for (int k = 0; k < 4; k++)
            begin
                if (c.mask[k])
                begin
                    d   = nh[k] - g;
                    u   = (d < 0) ? -d : d;
                    any = 1'b1;
                    if (u > delta)
                        delta = u;
                end
            end
            if (any && delta != 64'd0 && delta <= {48'd0, model_cfg.max_step})
            begin
                acc = (delta * {32'd0, model_cfg.step_gain}) >> 16;
                res.cost    = (acc > 64'hFFFF) ? COST_MAX : acc[15:0];
                res.barrier = 1'b0;
            end
        end
        return res;
    endfunction

    // mostly back-to-back, some short gaps, a few long ones
    function automatic int pick_idle();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void add_row(int sel, int g, bit gv, int ch, bit cv, int w, int e,
                                    int s, int n, logic [3:0] m, bit b, bit fixed,
                                    int cost, bit bar);
        cell_row_t r;
        r.sel          = sel;
        r.stim.ground  = height_t'(g);
        r.stim.gv      = gv;
        r.stim.ceiling = height_t'(ch);
        r.stim.cv      = cv;
        r.stim.west    = height_t'(w);
        r.stim.east    = height_t'(e);
        r.stim.south   = height_t'(s);
        r.stim.north   = height_t'(n);
        r.stim.mask    = m;
        r.stim.border  = b;
        r.fixed        = fixed;
        r.want.cost    = 16'(cost);
        r.want.barrier = bar;
        rows.insert(rows.size(), r);
    endfunction

    task automatic send_cell(cell_t c, bit fixed, cost_t want);
        int gap;
        gap = pick_idle();
        repeat (gap)
        begin
            @(negedge clk);
            cell_if.valid <= 1'b0;
        end
        @(negedge clk);
        cell_if.valid          <= 1'b1;
        cell_if.ground_height  <= c.ground;
        cell_if.ground_valid   <= c.gv;
        cell_if.ceiling_height <= c.ceiling;
        cell_if.ceiling_valid  <= c.cv;
        cell_if.west_height    <= c.west;
        cell_if.east_height    <= c.east;
        cell_if.south_height   <= c.south;
        cell_if.north_height   <= c.north;
        cell_if.neighbour_mask <= c.mask;
        cell_if.on_border      <= c.border;
        do
            @(posedge clk);
        while (cell_if.ready !== 1'b1);
        pending_costs.insert(pending_costs.size(), fixed ? want : predict_cost(c));
    endtask

    // registers change only with the pipeline empty
    task automatic write_cfg(ctc_cfg_t k);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx = '{CFG_MIN_HEADROOM, CFG_SLOPE_LIMIT_SQ, CFG_SLOPE_GAIN,
                CFG_MAX_STEP, CFG_STEP_GAIN, CFG_BARRIER_COST};
        val = '{40'(k.min_headroom), k.slope_limit_sq, 40'(k.slope_gain),
                40'(k.max_step), 40'(k.step_gain), 40'(k.barrier_cost)};
        @(negedge clk);
        cell_if.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(negedge clk);
        for (int i = 0; i < 6; i++)
        begin
            @(negedge clk);
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
        end
        @(negedge clk);
        cfg_we    <= 1'b0;
        model_cfg = k;
    endtask

    // cost side: random stalls, one long hold on request
    initial
    begin
        int stall;
        int run;
        cost_if.ready = 1'b0;
        forever
        begin
            if (hold_now)
            begin
                hold_now = 1'b0;
                stall    = LONG_HOLD;
            end
            else
                stall = pick_idle();
            run = quiet ? 50 : $urandom_range(1, 12);
            repeat (stall)
            begin
                @(negedge clk);
                cost_if.ready <= 1'b0;
            end
            repeat (run)
            begin
                @(negedge clk);
                cost_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cost_if.valid && cost_if.ready)
            begin
                if (pending_costs.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("cost beat with no cell pending: cost %h barrier %b",
                                 cost_if.cost, cost_if.is_barrier);
                    mismatches++;
                end
                else
                begin
                    oldest = pending_costs.pop_front();
                    if (oldest.cost !== cost_if.cost || oldest.barrier !== cost_if.is_barrier)
                    begin
                        if (mismatches < 10)
                            $display({"cost mismatch: expected cost %h barrier %b, ",
                                      "got cost %h barrier %b"},
                                     oldest.cost, oldest.barrier,
                                     cost_if.cost, cost_if.is_barrier);
                        mismatches++;
                    end
                end
            end
            if ((cost_if.valid && cost_if.ready) || (cell_if.valid && cell_if.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        cell_t    c;
        ctc_cfg_t k;
        int       cur_sel;
        int       pick;
        int       sp;
        int       base;
        int       sel;

        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        cell_if.valid          = 1'b0;
        cell_if.ground_height  = '0;
        cell_if.ground_valid   = 1'b0;
        cell_if.ceiling_height = '0;
        cell_if.ceiling_valid  = 1'b0;
        cell_if.west_height    = '0;
        cell_if.east_height    = '0;
        cell_if.south_height   = '0;
        cell_if.north_height   = '0;
        cell_if.neighbour_mask = '0;
        cell_if.on_border      = 1'b0;

        presets[PRESET_RESET] = '{RST_MIN_HEADROOM, RST_SLOPE_LIMIT_SQ, RST_SLOPE_GAIN,
                                  RST_MAX_STEP, RST_STEP_GAIN, RST_BARRIER_COST};
        presets[PRESET_STEP]  = '{16'd0, 40'd10000, 32'h8000_0000, 16'd200,
                                  32'h0001_8000, COST_MAX};
        presets[PRESET_MAX]   = '{16'hFFFF, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                                  32'hFFFF_FFFF, COST_MAX};
        presets[PRESET_ZERO]  = '{16'd0, 40'd0, 32'd0, 16'd0, 32'd0, 16'd0};
        presets[PRESET_MID]   = '{16'd300, 40'd250000, 32'h0100_0000, 16'd1000,
                                  32'h0000_4000, 16'd25600};
        model_cfg = presets[PRESET_RESET];
        cur_sel   = PRESET_RESET;

        // settings after reset: short headroom, validity corners, borders, extremes
        add_row(PRESET_RESET, 0, 1, 500, 1, 0, 0, 0, 0, 4'hF, 0, 1, 12800, 1);
        add_row(PRESET_RESET, 100, 1, -100, 1, 100, 100, 100, 100, 4'hF, 0, 1, 12800, 1);
        add_row(PRESET_RESET, 0, 1, 999, 1, 0, 0, 0, 0, 4'hF, 0, 1, 12800, 1);
        add_row(PRESET_RESET, 0, 1, 1000, 1, 0, 0, 0, 0, 4'hF, 0, 1, 0, 0);
        add_row(PRESET_RESET, 0, 1, 0, 0, 0, 0, 0, 0, 4'hF, 0, 1, 0, 0);
        add_row(PRESET_RESET, 5000, 0, 0, 1, 7, -7, 3, 9, 4'h0, 0, 1, 0, 0);
        add_row(PRESET_RESET, 0, 1, 2000, 1, 0, 0, 0, 0, 4'h1, 0, 1, 12800, 1);
        add_row(PRESET_RESET, 0, 1, 2000, 1, 0, 0, 0, 0, 4'h0, 1, 1, 0, 0);
        add_row(PRESET_RESET, 0, 1, 10, 1, 0, 0, 0, 0, 4'hF, 1, 1, 12800, 1);
        add_row(PRESET_RESET, -524288, 1, 0, 0, 524287, 524287, 524287, 524287, 4'hF, 0,
                1, 12800, 1);
        add_row(PRESET_RESET, 524287, 1, -524288, 1, 0, 0, 0, 0, 4'hF, 0, 1, 12800, 1);
        add_row(PRESET_RESET, -524288, 1, 524287, 1, -524288, -524288, -524288, -524288,
                4'hF, 0, 1, 0, 0);
        // slope and step paths
        add_row(PRESET_STEP, 0, 1, 0, 1, 50, -50, -50, 50, 4'hF, 0, 1, 2500, 0);
        add_row(PRESET_STEP, 0, 1, 0, 0, 150, 0, 0, 0, 4'h1, 0, 1, 225, 0);
        add_row(PRESET_STEP, 0, 1, 0, 0, 300, 0, 0, 0, 4'h1, 0, 1, 16'hFFFF, 1);
        add_row(PRESET_STEP, 0, 1, 0, 0, -200, 0, 0, 0, 4'h1, 0, 1, 300, 0);
        add_row(PRESET_STEP, 0, 1, 0, 0, 40, 40, 40, 40, 4'h0, 0, 1, 16'hFFFF, 1);
        add_row(PRESET_STEP, 0, 0, 0, 0, 40, 40, 40, 40, 4'hF, 0, 1, 16'hFFFF, 1);
        add_row(PRESET_STEP, 0, 1, 0, 0, 0, 0, 0, 0, 4'h1, 0, 1, 16'hFFFF, 1);
        add_row(PRESET_STEP, 0, 1, 0, 0, 71, -71, 71, -71, 4'hF, 0, 0, 0, 0);
        add_row(PRESET_STEP, 0, 1, 0, 0, 100, 0, 0, 0, 4'hF, 0, 1, 5000, 0);
        // every register at its top value
        add_row(PRESET_MAX, 0, 1, 65534, 1, 0, 0, 0, 0, 4'hF, 0, 1, 16'hFFFF, 1);
        add_row(PRESET_MAX, 0, 1, 65535, 1, 0, 0, 0, 0, 4'hF, 0, 1, 0, 0);
        add_row(PRESET_MAX, -524288, 1, 0, 0, 524287, 524287, 524287, 524287, 4'hF, 0,
                0, 0, 0);
        add_row(PRESET_MAX, 0, 1, 0, 0, 1000, -1000, 1000, -1000, 4'hF, 0, 1, 16'hFFFF, 0);
        // every register zero: a barrier that costs nothing
        add_row(PRESET_ZERO, 0, 1, 0, 1, 0, 0, 0, 0, 4'hF, 0, 1, 0, 0);
        add_row(PRESET_ZERO, 0, 1, 0, 1, 1, 0, 0, 0, 4'hF, 0, 1, 0, 1);

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            if (rows[i].sel != cur_sel)
            begin
                write_cfg(presets[rows[i].sel]);
                cur_sel = rows[i].sel;
            end
            send_cell(rows[i].stim, rows[i].fixed, rows[i].want);
        end

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: sel = PRESET_MID;
                1: sel = PRESET_STEP;
                2: sel = PRESET_MAX;
                3: sel = PRESET_ZERO;
                default: sel = -1;
            endcase
            if (sel >= 0)
                k = presets[sel];
            else
            begin
                k.min_headroom   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 2500));
                k.slope_limit_sq = ($urandom_range(0, 3) == 0) ? {8'($urandom), 32'($urandom)}
                                                               : 40'($urandom_range(0, 2000000));
                k.slope_gain     = $urandom;
                k.max_step       = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                               : 16'($urandom_range(0, 3000));
                k.step_gain      = $urandom;
                k.barrier_cost   = 16'($urandom);
            end
            write_cfg(k);
            quiet = (ph == 1);
            if (ph == 4)
                hold_now = 1'b1;

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    c = CELL_W'({$urandom, $urandom, $urandom, $urandom});
                else
                begin
                    // terrain-like cell: neighbours scattered around the ground height
                    case ($urandom_range(0, 3))
                        0: sp = 20;
                        1: sp = 150;
                        2: sp = 1200;
                        default: sp = 20000;
                    endcase
                    if (pick == 9)
                        base = $urandom_range(0, 1) ? 524287 - sp / 2 : -524288 + sp / 2;
                    else
                        base = int'($urandom_range(0, 1000000)) - 500000;
                    c.ground  = height_t'(base);
                    c.west    = height_t'(base + int'($urandom_range(0, 2 * sp)) - sp);
                    c.east    = height_t'(base + int'($urandom_range(0, 2 * sp)) - sp);
                    c.south   = height_t'(base + int'($urandom_range(0, 2 * sp)) - sp);
                    c.north   = height_t'(base + int'($urandom_range(0, 2 * sp)) - sp);
                    c.ceiling = height_t'(base - 500 + int'($urandom_range(0,
                                    2 * int'(model_cfg.min_headroom) + 3000)));
                    c.gv      = ($urandom_range(0, 19) != 0);
                    c.cv      = ($urandom_range(0, 5) != 0);
                    c.mask    = ($urandom_range(0, 4) != 0) ? 4'hF : 4'($urandom);
                    c.border  = ($urandom_range(0, 19) == 0);
                end
                send_cell(c, 1'b0, '0);
            end
        end
        quiet = 1'b0;

        @(negedge clk);
        cell_if.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: cell_traversability_cost.f
src/ctc_pkg.sv
src/ctc_if.sv
src/ctc_diff.sv
src/ctc_slope.sv
src/ctc_cost.sv
src/cell_traversability_cost.sv
tb/tb_cell_traversability_cost.sv
